[src/rbct_pkg.sv]
// Package for the received block contiguity tracker.
// Holds the id width and the outcome codes; no dependencies.
`default_nettype none

package rbct_pkg;

   localparam int ID_W = 16;

   // Outcome code returned with each result
   typedef enum logic [1:0] {
      OUT_FIRST   = 2'd0,
      OUT_STORED  = 2'd1,
      OUT_OLD     = 2'd2,
      OUT_DROPPED = 2'd3
   } outcome_type;

endpackage

`default_nettype wire

[src/received_block_contiguity_tracker.sv]
// Received block contiguity tracker: accepts one id per cycle while busy is low.
// Each id is registered, then compared with the run state, stored in the
// window bitmap and the run advanced combinationally before the result register.
// Synchronous reset clears the run state and bitmap; busy is high during reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module received_block_contiguity_tracker #(
   parameter int WINDOW = 64
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [rbct_pkg::ID_W-1:0] req_block_id,
   output logic                          rsp_valid,
   output logic      [rbct_pkg::ID_W-1:0] rsp_run_end,
   output logic      [rbct_pkg::ID_W-1:0] rsp_highest_seen,
   output logic      [1:0]               rsp_outcome
);

   import rbct_pkg::*;

   localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W = $clog2(WINDOW + 1);

   // Input stage
   logic               busy_ff;
   logic               req_vld_ff;
   logic [ID_W-1:0]    req_id_ff;

   // Tracker state
   logic               holds_any_ff, holds_any_in;
   logic [ID_W-1:0]    end_ff, end_in;
   logic [ID_W-1:0]    max_ff, max_in;
   logic [WINDOW-1:0]  map_ff, map_in;

   // Result stage
   logic               rsp_vld_ff;
   logic [ID_W-1:0]    rsp_end_ff;
   logic [ID_W-1:0]    rsp_max_ff;
   outcome_type        rsp_out_ff;
   outcome_type        outcome;

   // Compare and store
   logic [ID_W-1:0]    gap;
   logic [IDX_W-1:0]   idx;
   logic               is_old;
   logic               in_win;
   logic               is_dup;
   logic [WINDOW-1:0]  set_mask;
   logic [WINDOW-1:0]  map_set;
   logic [CNT_W-1:0]   run;
   logic [WINDOW-1:0]  map_adv;

   assign busy = busy_ff;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         req_vld_ff <= 1'b0;
      end else begin
         busy_ff    <= 1'b0;
         req_vld_ff <= start && !busy_ff;
      end
      req_id_ff <= req_block_id;
   end

   // Distance above the run end, valid when the id is not old
   assign is_old = req_id_ff <= end_ff;
   assign gap    = req_id_ff - end_ff;
   assign in_win = gap <= ID_W'(WINDOW);
   assign idx    = IDX_W'(gap - ID_W'(1));
   assign is_dup = map_ff[idx];

   always_comb begin
      for (int i = 0; i < WINDOW; i++) begin
         set_mask[i] = (idx == IDX_W'(i));
      end
   end

   assign map_set = map_ff | set_mask;

   rbct_advance #(
      .WINDOW (WINDOW)
   ) u_advance (
      .map_i (map_set),
      .run_o (run),
      .map_o (map_adv)
   );

   // Next state and outcome
   always_comb begin
      holds_any_in = holds_any_ff;
      end_in       = end_ff;
      max_in       = max_ff;
      map_in       = map_ff;
      outcome      = OUT_OLD;
      if (req_vld_ff) begin
         if (!holds_any_ff) begin
            holds_any_in = 1'b1;
            end_in       = req_id_ff;
            max_in       = req_id_ff;
            map_in       = '0;
            outcome      = OUT_FIRST;
         end else if (is_old) begin
            outcome = OUT_OLD;
         end else if (!in_win) begin
            outcome = OUT_DROPPED;
         end else if (is_dup) begin
            outcome = OUT_OLD;
         end else begin
            outcome = OUT_STORED;
            if (req_id_ff > max_ff) begin
               max_in = req_id_ff;
            end
            if (gap == ID_W'(1)) begin
               end_in = end_ff + ID_W'(run);
               map_in = map_adv;
            end else begin
               map_in = map_set;
            end
         end
      end
   end

   // State and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         holds_any_ff <= 1'b0;
         end_ff       <= '0;
         max_ff       <= '0;
         map_ff       <= '0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         holds_any_ff <= holds_any_in;
         end_ff       <= end_in;
         max_ff       <= max_in;
         map_ff       <= map_in;
         rsp_vld_ff   <= req_vld_ff;
      end
      rsp_end_ff <= end_in;
      rsp_max_ff <= max_in;
      rsp_out_ff <= outcome;
   end

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_run_end      = rsp_end_ff;
   assign rsp_highest_seen = rsp_max_ff;
   assign rsp_outcome      = rsp_out_ff;

   // Every accepted id produces a result after the input and result registers
   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("accepted id produced no result");

   // Bit 0 of the window would have advanced the run
   a_low_bit_clear: assert property (@(posedge clock) disable iff (reset)
      !map_ff[0])
      else $error("window bit 0 left set");

   // The run end only moves up once an id is held
   a_end_monotonic: assert property (@(posedge clock) disable iff (reset)
      (holds_any_ff && $past(holds_any_ff)) |-> (end_ff >= $past(end_ff)))
      else $error("run end moved down");

   // The run never reaches past the highest id held
   a_end_below_max: assert property (@(posedge clock) disable iff (reset)
      holds_any_ff |-> (end_ff <= max_ff))
      else $error("run end above highest id");

   // Nothing is held before the first id
   a_empty_before_first: assert property (@(posedge clock) disable iff (reset)
      !holds_any_ff |-> (map_ff == '0))
      else $error("window bits set before first id");

endmodule

`default_nettype wire

[src/rbct_advance.sv]
// Run advance unit: counts the trailing ones of the window bitmap and shifts
// the bitmap down past them. Depends on nothing but its parameter.
`default_nettype none

module rbct_advance #(
   parameter int WINDOW = 64
) (
   input  wire logic [WINDOW-1:0]             map_i,
   output logic      [$clog2(WINDOW+1)-1:0]   run_o,
   output logic      [WINDOW-1:0]             map_o
);

   localparam int CNT_W = $clog2(WINDOW + 1);

   logic [CNT_W-1:0] run;

   // Lowest clear bit; all ones means the whole window is consumed
   always_comb begin
      run = CNT_W'(WINDOW);
      for (int i = WINDOW - 1; i >= 0; i--) begin
         if (!map_i[i]) begin
            run = CNT_W'(i);
         end
      end
   end

   assign run_o = run;
   assign map_o = map_i >> run;

endmodule

`default_nettype wire

[sim/received_block_contiguity_tracker_tb.sv]
// Testbench for received_block_contiguity_tracker: random and directed block ids,
// every result checked against a cycle-free tracker model kept in the bench.
// Depends on rbct_pkg and the tracker RTL only.
`timescale 1ns / 1ps

module received_block_contiguity_tracker_tb;
   import rbct_pkg::*;

   localparam int WINDOW     = 64;
   localparam int ID_MAX     = 65535;
   localparam int FIRST_ID   = ID_MAX - 450;  // leaves room to reach the top of id space
   localparam int LATENCY    = 2;
   localparam int CYCLE_CAP  = 200000;
   localparam int SHOW_ERRS  = 10;

   // Run state of the tracker
   typedef struct packed {
      logic              holds_any;
      logic [ID_W-1:0]   run_end;
      logic [ID_W-1:0]   max_id;
      logic [WINDOW-1:0] ahead;
   } tracker_state_type;

   // One result transaction
   typedef struct packed {
      logic [ID_W-1:0] run_end;
      logic [ID_W-1:0] highest;
      outcome_type     outcome;
   } track_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic [ID_W-1:0]   req_block_id = '0;
   logic              busy;
   logic              rsp_valid;
   logic [ID_W-1:0]   rsp_run_end;
   logic [ID_W-1:0]   rsp_highest_seen;
   logic [1:0]        rsp_outcome;

   tracker_state_type plan_state  = '0;   // state after every id queued so far
   tracker_state_type check_state = '0;   // state after every id accepted so far
   logic [ID_W-1:0]   pending_ids[$];
   track_result_type  expected_results[$];
   int                idle_pct = 0;
   int                planned_stores = 0;
   int                outcome_count[4] = '{0, 0, 0, 0};
   int                accepted = 0;
   int                mismatches = 0;
   int                cycle_count = 0;

   received_block_contiguity_tracker #(
      .WINDOW(WINDOW)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_block_id(req_block_id),
      .rsp_valid(rsp_valid),
      .rsp_run_end(rsp_run_end),
      .rsp_highest_seen(rsp_highest_seen),
      .rsp_outcome(rsp_outcome)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Apply one received id to a tracker state, return the result it produces
   function automatic track_result_type track_id(inout tracker_state_type st,
                                                 input logic [ID_W-1:0] id);
      track_result_type r;
      int               gap;
      int               run;
      if (!st.holds_any) begin
         st.holds_any = 1'b1;
         st.run_end   = id;
         st.max_id    = id;
         st.ahead     = '0;
         r.outcome    = OUT_FIRST;
      end else if (id <= st.run_end) begin
         r.outcome = OUT_OLD;
      end else begin
         gap = int'(id) - int'(st.run_end);
         if (gap > WINDOW) begin
            r.outcome = OUT_DROPPED;
         end else if (st.ahead[gap-1]) begin
            r.outcome = OUT_OLD;
         end else begin
            st.ahead[gap-1] = 1'b1;
            if (id > st.max_id)
               st.max_id = id;
            // next id in line: absorb every directly following held id
            if (gap == 1) begin
               run = 0;
               while (run < WINDOW && st.ahead[run])
                  run++;
               st.run_end = ID_W'(int'(st.run_end) + run);
               st.ahead   = st.ahead >> run;
            end
            r.outcome = OUT_STORED;
         end
      end
      r.run_end = st.run_end;
      r.highest = st.max_id;
      return r;
   endfunction

   // Queue an id for the driver, tracking where the run will stand
   task automatic queue_id(input logic [ID_W-1:0] id);
      track_result_type r;
      r = track_id(plan_state, id);
      pending_ids.push_back(id);
      if (r.outcome == OUT_STORED)
         planned_stores++;
   endtask

   // Queue the next n ids above the run end in shuffled order, optionally with repeats
   task automatic queue_run(input int n, input bit with_dups);
      logic [ID_W-1:0] ids[$];
      logic [ID_W-1:0] tmp;
      int              hi;
      int              j;
      hi = int'(plan_state.run_end) + n;
      if (hi > ID_MAX)
         hi = ID_MAX;
      for (int v = int'(plan_state.run_end) + 1; v <= hi; v++)
         ids.push_back(ID_W'(v));
      for (int i = ids.size() - 1; i > 0; i--) begin
         j      = $urandom_range(i, 0);
         tmp    = ids[i];
         ids[i] = ids[j];
         ids[j] = tmp;
      end
      foreach (ids[i]) begin
         queue_id(ids[i]);
         if (with_dups && $urandom_range(9) == 0)
            queue_id(ids[$urandom_range(i, 0)]);
      end
   endtask

   // Random mix until the planned store count reaches stop_at or the run tops out
   task automatic queue_random(input int stop_at);
      int kind;
      int base;
      while (planned_stores < stop_at && plan_state.run_end != ID_W'(ID_MAX)) begin
         kind = $urandom_range(99);
         base = int'(plan_state.run_end);
         if (kind < 55) begin
            queue_run($urandom_range(64, 1), 1'b1);
         end else if (kind < 75) begin
            // scattered ids inside the window
            repeat ($urandom_range(4, 1))
               if (base < ID_MAX)
                  queue_id(ID_W'((base + $urandom_range(WINDOW, 1) > ID_MAX) ?
                                 ID_MAX : base + $urandom_range(WINDOW, 1)));
         end else if (kind < 88) begin
            // noise: old ids or anything at all
            if ($urandom_range(1))
               queue_id(ID_W'($urandom_range(base, 0)));
            else
               queue_id(ID_W'($urandom));
         end else begin
            if (base + WINDOW + 1 <= ID_MAX)
               queue_id(ID_W'($urandom_range(ID_MAX, base + WINDOW + 1)));
            else
               queue_id(ID_W'($urandom));
         end
      end
   endtask

   // Hold off new ids until the block has answered everything
   task automatic drain;
      while (pending_ids.size() != 0 || expected_results.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   // Driver: offer the next pending id at the falling edge
   always @(negedge clock) begin
      if (!reset && pending_ids.size() != 0 && $urandom_range(99) >= idle_pct) begin
         start        <= 1'b1;
         req_block_id <= pending_ids[0];
      end else begin
         start        <= 1'b0;
         req_block_id <= ID_W'($urandom);
      end
   end

   // Monitor: predict on each accepted id, check each strobed result
   always @(posedge clock) begin
      track_result_type exp_r;
      track_result_type got_r;
      if (!reset && start && !busy) begin
         exp_r = track_id(check_state, req_block_id);
         expected_results.push_back(exp_r);
         outcome_count[exp_r.outcome]++;
         accepted++;
         void'(pending_ids.pop_front());
      end
      if (!reset && rsp_valid) begin
         got_r.run_end = rsp_run_end;
         got_r.highest = rsp_highest_seen;
         got_r.outcome = outcome_type'(rsp_outcome);
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOW_ERRS)
               $display("%0t: result with nothing expected: run_end %0d highest %0d outcome %0d",
                        $time, got_r.run_end, got_r.highest, got_r.outcome);
         end else begin
            exp_r = expected_results.pop_front();
            if (got_r.run_end !== exp_r.run_end || got_r.highest !== exp_r.highest ||
                got_r.outcome !== exp_r.outcome) begin
               mismatches++;
               if (mismatches <= SHOW_ERRS)
                  $display("%0t: mismatch run_end %0d/%0d highest %0d/%0d outcome %0d/%0d",
                           $time, exp_r.run_end, got_r.run_end, exp_r.highest,
                           got_r.highest, exp_r.outcome, got_r.outcome);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_CAP) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Stimulus sequence
   initial begin
      int base;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: first id, old ids, window edges, duplicates, run advance
      idle_pct = 0;
      queue_id(ID_W'(FIRST_ID));
      queue_id(ID_W'(FIRST_ID));
      queue_id('0);
      queue_id(ID_W'(FIRST_ID + WINDOW));
      queue_id(ID_W'(FIRST_ID + WINDOW + 1));
      queue_id(ID_W'(ID_MAX));
      queue_id(ID_W'(FIRST_ID + 2));
      queue_id(ID_W'(FIRST_ID + 2));
      queue_id(ID_W'(FIRST_ID + WINDOW));
      queue_id(ID_W'(FIRST_ID + 1));
      queue_id(ID_W'(FIRST_ID + WINDOW + 2));
      queue_id(ID_W'(FIRST_ID + WINDOW + 3));
      queue_id(ID_W'(FIRST_ID + 3));
      queue_id(16'h5555);
      queue_id(16'hAAAA);
      drain();

      // Fill the whole window, then the next id in line sweeps the run across it
      base = int'(plan_state.run_end);
      for (int v = base + 2; v <= base + WINDOW; v++)
         queue_id(ID_W'(v));
      queue_id(ID_W'(base + 1));
      queue_random(planned_stores + 100);
      drain();

      idle_pct = 53;
      queue_random(planned_stores + 100);
      drain();

      idle_pct = 18;
      queue_random(planned_stores + 100);
      drain();

      // Climb to the top of the id space, then poke the top and bottom
      idle_pct = 0;
      while (plan_state.run_end != ID_W'(ID_MAX))
         queue_run($urandom_range(64, 1), 1'b0);
      queue_id(ID_W'(ID_MAX));
      queue_id('0);
      queue_id(ID_W'(FIRST_ID));
      drain();

      mismatches += expected_results.size();
      $display("Ran %0d ids: %0d stored, %0d old or duplicate, %0d beyond window, %0d first.",
               accepted, outcome_count[OUT_STORED], outcome_count[OUT_OLD],
               outcome_count[OUT_DROPPED], outcome_count[OUT_FIRST]);
      $display("Run climbed from %0d to %0d with sender gaps of 0, 53 and 18 percent.",
               FIRST_ID, check_state.run_end);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[received_block_contiguity_tracker.f]
src/rbct_pkg.sv
src/rbct_advance.sv
src/received_block_contiguity_tracker.sv
sim/received_block_contiguity_tracker_tb.sv
